### design/mahd_pkg.sv
// shared types, header codes and lookup tables for the audio header decoder
package mahd_pkg;

    // divider sizing: numerator, pre-shifted divisor, quotient bits
    localparam int NUM_W     = 29;
    localparam int DVS_W     = 30;
    localparam int QUO_W     = 11;
    localparam int NUM_CELLS = QUO_W;

    // stream kinds
    localparam logic KIND_MPEG = 1'b0;
    localparam logic KIND_ADTS = 1'b1;

    // version codes
    localparam logic [1:0] VER_MPEG25 = 2'd0;
    localparam logic [1:0] VER_RSVD   = 2'd1;
    localparam logic [1:0] VER_MPEG2  = 2'd2;
    localparam logic [1:0] VER_MPEG1  = 2'd3;

    // layer codes
    localparam logic [1:0] LAYER_RSVD = 2'd0;
    localparam logic [1:0] LAYER_III  = 2'd1;
    localparam logic [1:0] LAYER_II   = 2'd2;
    localparam logic [1:0] LAYER_I    = 2'd3;

    localparam logic [1:0] MODE_MONO = 2'd3;

    // samples per frame times 1000
    localparam logic [20:0] SPF_K_MPEG1 = 21'd1152000;
    localparam logic [20:0] SPF_K_OTHER = 21'd576000;

    localparam logic [8:0] ADTS_KBPS = 9'd16;

    // bitrate rows, kbit/s
    localparam logic [8:0] KBPS_LSF_L23 [16] = '{
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};
    localparam logic [8:0] KBPS_LSF_L1 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
    localparam logic [8:0] KBPS_V1_L3 [16] = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
    localparam logic [8:0] KBPS_V1_L2 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
    localparam logic [8:0] KBPS_V1_L1 [16] = '{
        9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};

    // ADTS sampling frequency table
    localparam logic [16:0] ADTS_HZ [16] = '{
        17'd96000, 17'd88200, 17'd64000, 17'd48000,
        17'd44100, 17'd32000, 17'd24000, 17'd22050,
        17'd16000, 17'd12000, 17'd11025, 17'd8000,
        17'd7350, 17'd0, 17'd0, 17'd0};

    // decoded header fields carried down the pipeline
    typedef struct packed {
        logic        valid_res;
        logic [1:0]  version_code;
        logic [1:0]  layer_code;
        logic [8:0]  bitrate_kbps;
        logic [16:0] samplerate_hz;
        logic [1:0]  channels;
        logic [2:0]  channel_config;
        logic [1:0]  channel_mode;
        logic [1:0]  mode_extension;
        logic        crc_protected;
        logic        padding;
    } hdr_fields_t;

    // one divider cell's word
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DVS_W-1:0] dvs;
        logic [QUO_W-1:0] quo;
        hdr_fields_t      hdr;
    } cell_data_t;

    // mpeg bitrate lookup
    function automatic logic [8:0] mpa_kbps(logic [1:0] ver, logic [1:0] lay,
                                            logic [3:0] idx);
        logic       v1;
        logic [8:0] k;
        v1 = (ver == VER_MPEG1);
        unique case (lay)
            LAYER_III: k = v1 ? KBPS_V1_L3[idx] : KBPS_LSF_L23[idx];
            LAYER_II:  k = v1 ? KBPS_V1_L2[idx] : KBPS_LSF_L23[idx];
            LAYER_I:   k = v1 ? KBPS_V1_L1[idx] : KBPS_LSF_L1[idx];
            default:   k = 9'd0;
        endcase
        return k;
    endfunction

    // mpeg sample rate lookup
    function automatic logic [16:0] mpa_hz(logic [1:0] ver, logic [1:0] idx);
        logic [16:0] h;
        unique case ({ver, idx})
            {VER_MPEG1, 2'd0}:  h = 17'd44100;
            {VER_MPEG1, 2'd1}:  h = 17'd48000;
            {VER_MPEG1, 2'd2}:  h = 17'd32000;
            {VER_MPEG2, 2'd0}:  h = 17'd22050;
            {VER_MPEG2, 2'd1}:  h = 17'd24000;
            {VER_MPEG2, 2'd2}:  h = 17'd16000;
            {VER_MPEG25, 2'd0}: h = 17'd11025;
            {VER_MPEG25, 2'd1}: h = 17'd12000;
            {VER_MPEG25, 2'd2}: h = 17'd8000;
            default:            h = 17'd0;
        endcase
        return h;
    endfunction

endpackage

### design/mahd_decode.sv
// front stage: sync check, field decode, table lookups and frame numerator
module mahd_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                stream_kind,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         header_word,
    output logic                out_valid,
    input  logic                out_ready,
    output mahd_pkg::cell_data_t out_data
);
    import mahd_pkg::*;

    logic        valid_reg;
    cell_data_t  data_reg;
    cell_data_t  data_next;

    logic [1:0]  ver;
    logic [1:0]  lay;
    logic        decoded;
    logic        ok;
    logic [20:0] spf_k;
    logic [29:0] num_full;
    hdr_fields_t f;

    assign ver = header_word[19:18];
    assign lay = header_word[18:17];

    // decode fields for the selected stream kind
    always_comb
    begin
        f                = '0;
        f.version_code   = ver;
        f.layer_code     = lay;
        ok               = 1'b0;
        decoded          = 1'b0;
        if (stream_kind == KIND_MPEG)
        begin
            decoded = (ver != VER_MPEG25) && (lay != LAYER_RSVD);
            if (decoded)
            begin
                f.crc_protected  = ~header_word[16];
                f.padding        = header_word[9];
                f.channel_mode   = header_word[7:6];
                f.mode_extension = header_word[5:4];
                f.bitrate_kbps   = mpa_kbps(ver, lay, header_word[15:12]);
                f.samplerate_hz  = mpa_hz(ver, header_word[11:10]);
            end
            ok = decoded && (header_word[31:21] == 11'h7FF)
                 && (f.bitrate_kbps != 9'd0) && (f.samplerate_hz != 17'd0);
        end
        else
        begin
            decoded = (ver == VER_MPEG25) && (lay == LAYER_RSVD);
            if (decoded)
            begin
                f.crc_protected  = ~header_word[16];
                f.samplerate_hz  = ADTS_HZ[header_word[15:12]];
                f.channel_config = header_word[8:6];
                f.bitrate_kbps   = ADTS_KBPS;
            end
            ok = decoded && (header_word[31:20] == 12'hFFF)
                 && (f.samplerate_hz != 17'd0);
        end
        f.valid_res = ok;
        f.channels  = (f.channel_mode == MODE_MONO) ? 2'd1 : 2'd2;
    end

    // samples * kbps * 1000, divisor 8 * hz pre-shifted for the top quotient bit
    assign spf_k    = (ver == VER_MPEG1) ? SPF_K_MPEG1 : SPF_K_OTHER;
    assign num_full = {9'b0, spf_k} * {21'b0, f.bitrate_kbps};

    always_comb
    begin
        data_next.rem = num_full[NUM_W-1:0];
        data_next.dvs = DVS_W'({f.samplerate_hz, 3'b0, {(QUO_W-1){1'b0}}});
        data_next.quo = '0;
        data_next.hdr = f;
    end

    assign in_ready  = ~valid_reg | out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

### design/mahd_cell.sv
// one restoring division cell: resolves one quotient bit per word
module mahd_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mahd_pkg::cell_data_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mahd_pkg::cell_data_t out_data
);
    import mahd_pkg::*;

    logic             valid_reg;
    cell_data_t       data_reg;
    cell_data_t       data_next;
    logic [DVS_W-1:0] rem_ext;
    logic [DVS_W-1:0] diff;
    logic             take;

    // compare and subtract the shifted divisor
    assign rem_ext = {{(DVS_W-NUM_W){1'b0}}, in_data.rem};
    assign take    = (rem_ext >= in_data.dvs);
    assign diff    = rem_ext - in_data.dvs;

    always_comb
    begin
        data_next.rem = take ? diff[NUM_W-1:0] : in_data.rem;
        data_next.dvs = in_data.dvs >> 1;
        data_next.quo = {in_data.quo[QUO_W-2:0], take};
        data_next.hdr = in_data.hdr;
    end

    assign in_ready  = ~valid_reg | out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // cell valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // cell payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

### design/mpeg_audio_header_decode_core.sv
// top level: mpeg audio / adts header decoder with a chain of divider cells
//
//  channel   signals                          direction  notes
//  cfg       cfg_wr_en, cfg_wr_data           in         stream kind, 0 mpeg, 1 adts
//  in        in_valid/in_ready, header_word   in         one header word per item
//  out       out_valid/out_ready, fields      out        one decoded word per item
//
// one word accepted per cycle while the output is not stalled; one decode stage plus
// 11 division cells, one frame-length quotient bit per cell
// each stage holds its word while stalled and frees as soon as the next takes it,
// so a waiting result never blocks new input while earlier stages have room
// reset clears the stage valid bits and sets the stream kind to mpeg
module mpeg_audio_header_decode_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] header_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        valid_res,
    output logic [1:0]  version_code,
    output logic [1:0]  layer_code,
    output logic [8:0]  bitrate_kbps,
    output logic [16:0] samplerate_hz,
    output logic [1:0]  channels,
    output logic [2:0]  channel_config,
    output logic [1:0]  channel_mode,
    output logic [1:0]  mode_extension,
    output logic        crc_protected,
    output logic        padding,
    output logic [11:0] frame_bytes
);
    import mahd_pkg::*;

    logic       stream_kind_reg;
    logic       stage_valid [NUM_CELLS+1];
    logic       stage_ready [NUM_CELLS+1];
    cell_data_t stage_data  [NUM_CELLS+1];
    cell_data_t last;

    // stream kind register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stream_kind_reg <= KIND_MPEG;
        else if (cfg_wr_en)
            stream_kind_reg <= cfg_wr_data;
    end

    // decode stage
    mahd_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .stream_kind (stream_kind_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .header_word (header_word),
        .out_valid   (stage_valid[0]),
        .out_ready   (stage_ready[0]),
        .out_data    (stage_data[0])
    );

    // division cell chain
    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        mahd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[g]),
            .in_ready  (stage_ready[g]),
            .in_data   (stage_data[g]),
            .out_valid (stage_valid[g+1]),
            .out_ready (stage_ready[g+1]),
            .out_data  (stage_data[g+1])
        );
    end

    assign stage_ready[NUM_CELLS] = out_ready;
    assign last                   = stage_data[NUM_CELLS];
    assign out_valid              = stage_valid[NUM_CELLS];

    // output word
    assign valid_res      = last.hdr.valid_res;
    assign version_code   = last.hdr.version_code;
    assign layer_code     = last.hdr.layer_code;
    assign bitrate_kbps   = last.hdr.bitrate_kbps;
    assign samplerate_hz  = last.hdr.samplerate_hz;
    assign channels       = last.hdr.channels;
    assign channel_config = last.hdr.channel_config;
    assign channel_mode   = last.hdr.channel_mode;
    assign mode_extension = last.hdr.mode_extension;
    assign crc_protected  = last.hdr.crc_protected;
    assign padding        = last.hdr.padding;

    // frame length is zero when no sample rate is known
    assign frame_bytes = (last.hdr.samplerate_hz != 17'd0)
                         ? ({1'b0, last.quo} + {11'b0, last.hdr.padding})
                         : 12'd0;

endmodule
